FILE: hw/rtl/ept_pkg.sv
// Shared types and constants of the elitist pheromone table update block.
package ept_pkg;

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_EVAP    = 3'd1;
    localparam logic [2:0] CMD_DEP_PRI = 3'd2;
    localparam logic [2:0] CMD_DEP_SEC = 3'd3;
    localparam logic [2:0] CMD_RD_PRI  = 3'd4;
    localparam logic [2:0] CMD_RD_SEC  = 3'd5;

    localparam logic [2:0] REG_TAU      = 3'd0;
    localparam logic [2:0] REG_EVAP     = 3'd1;
    localparam logic [2:0] REG_EVAP_SEC = 3'd2;
    localparam logic [2:0] REG_FLOOR    = 3'd3;
    localparam logic [2:0] REG_ELITE    = 3'd4;
    localparam logic [2:0] REG_SEC_EN   = 3'd5;

    localparam logic [31:0] TAU_RESET      = 32'd65536;
    localparam logic [15:0] EVAP_RESET     = 16'd6554;
    localparam logic [15:0] ELITE_RESET    = 16'd256;
    localparam logic [31:0] MAX_VALUE      = 32'hFFFF_FFFF;
    localparam int          DIV_STEPS      = 56;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  arc_index;
        logic [23:0] tour_length;
        logic [7:0]  passes;
        logic        elite;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  result_arc;
        logic [31:0] pheromone;
        logic        done_res;
    } out_item_t;

    typedef enum logic [2:0] {
        RES_NONE     = 3'd0,
        RES_ZERO_ARC = 3'd1,
        RES_ENTRY    = 3'd2,
        RES_NEW      = 3'd3,
        RES_SWEEP    = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      addr_clr;
        logic      fill;
        logic      fill_reset;
        logic      ev_rd;
        logic      ev_wr;
        logic      dp_rd;
        logic      mul1;
        logic      mul2;
        logic      mul3;
        logic      div_step;
        logic      dp_wr;
        logic      set_res;
        res_kind_t res_kind;
        logic      load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] in_cmd;
        logic       arc_ok;
        logic       dep_ok;
        logic       last_addr;
        logic       div_last;
        logic       out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/elitist_pheromone_table_update_top.sv
// Top level of the elitist pheromone table update block: controller and datapath.
// A read or no-op deposit returns the stored entry; a deposit computes its amount in the
// divider (one quotient bit per cycle) and writes back the saturated sum; an unknown command
// returns a zero result; init fills both tables; evaporation sweeps (read, then write, per entry).
// One request is in progress at a time; the next is taken in the cycle after the result is loaded.
// After reset a clearing pass fills both tables; no request is taken meanwhile.
module elitist_pheromone_table_update_top
    import ept_pkg::*;
#(
    parameter int NUM_ARCS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ept_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ept_datapath #(
        .NUM_ARCS (NUM_ARCS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: hw/rtl/ept_datapath.sv
// Datapath: configuration registers, both pheromone tables, multipliers, divider and result register.
module ept_datapath
    import ept_pkg::*;
#(
    parameter int NUM_ARCS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  in_item_t    s_data,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int ARC_W = (NUM_ARCS > 1) ? $clog2(NUM_ARCS) : 1;
    localparam logic [31:0] NUM_ARCS_W = 32'(NUM_ARCS);
    localparam logic [ARC_W-1:0] LAST_ADDR = ARC_W'(NUM_ARCS - 1);

    logic [31:0] tau_reg;
    logic [15:0] evap_rate_reg;
    logic [15:0] evap_rate_sec_reg;
    logic [31:0] floor_reg;
    logic [15:0] elite_factor_reg;
    logic        sec_en_reg;

    in_item_t    item_reg;
    logic [ARC_W-1:0] addr_reg;
    logic [31:0] prim_mem [NUM_ARCS];
    logic [31:0] sec_mem [NUM_ARCS];
    logic [31:0] prim_rd_reg;
    logic [31:0] sec_rd_reg;
    logic [31:0] sweep_val_reg;

    logic [47:0] ll_reg;
    logic [47:0] et_reg;
    logic [63:0] llr_reg;
    logic [71:0] den_reg;
    logic [71:0] rem_reg;
    logic [55:0] quo_reg;
    logic [5:0]  div_cnt_reg;

    out_item_t   res_reg;
    out_item_t   m_data_reg;
    logic        m_valid_reg;

    logic [15:0]      arc_ext;
    logic [ARC_W-1:0] arc_addr;
    logic             sel_sec;
    logic [ARC_W-1:0] rd_addr;
    logic [31:0]      fill_val;
    logic [16:0]      keep_p;
    logic [16:0]      keep_s;
    logic [48:0]      prod_p;
    logic [48:0]      prod_s;
    logic [31:0]      prim_ev;
    logic [31:0]      sec_ev;
    logic [72:0]      rem_sh;
    logic             div_ge;
    logic [31:0]      amount;
    logic [31:0]      entry;
    logic [32:0]      sum;
    logic [31:0]      new_val;
    logic             prim_we;
    logic             sec_we;
    logic [ARC_W-1:0] wr_addr;
    logic [31:0]      prim_wdata;
    logic [31:0]      sec_wdata;
    out_item_t        res_next;

    assign arc_ext  = 16'(item_reg.arc_index);
    assign arc_addr = arc_ext[ARC_W-1:0];
    assign sel_sec  = (item_reg.command == CMD_DEP_SEC) || (item_reg.command == CMD_RD_SEC);
    assign rd_addr  = cmd.ev_rd ? addr_reg : arc_addr;
    assign fill_val = cmd.fill_reset ? TAU_RESET : tau_reg;

    assign keep_p  = 17'h10000 - 17'(evap_rate_reg);
    assign keep_s  = 17'h10000 - 17'(evap_rate_sec_reg);
    assign prod_p  = 49'(prim_rd_reg) * 49'(keep_p);
    assign prod_s  = 49'(sec_rd_reg) * 49'(keep_s);
    assign prim_ev = (prim_rd_reg < floor_reg) ? floor_reg : prod_p[47:16];
    assign sec_ev  = (sec_rd_reg < floor_reg) ? floor_reg : prod_s[47:16];

    assign rem_sh = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign div_ge = rem_sh >= {1'b0, den_reg};

    always_comb begin
        if (den_reg == '0) begin
            amount = MAX_VALUE;
        end else if (quo_reg[DIV_STEPS-1:32] != '0) begin
            amount = MAX_VALUE;
        end else begin
            amount = quo_reg[31:0];
        end
    end

    assign entry   = sel_sec ? sec_rd_reg : prim_rd_reg;
    assign sum     = 33'(entry) + 33'(amount);
    assign new_val = sum[32] ? MAX_VALUE : sum[31:0];

    always_comb begin
        prim_we    = 1'b0;
        sec_we     = 1'b0;
        wr_addr    = addr_reg;
        prim_wdata = fill_val;
        sec_wdata  = fill_val;
        if (cmd.fill) begin
            prim_we = 1'b1;
            sec_we  = 1'b1;
        end else if (cmd.ev_wr) begin
            prim_we    = 1'b1;
            sec_we     = sec_en_reg;
            prim_wdata = prim_ev;
            sec_wdata  = sec_ev;
        end else if (cmd.dp_wr) begin
            prim_we    = !sel_sec;
            sec_we     = sel_sec;
            wr_addr    = arc_addr;
            prim_wdata = new_val;
            sec_wdata  = new_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (prim_we) begin
            prim_mem[wr_addr] <= prim_wdata;
        end
        if (cmd.ev_rd || cmd.dp_rd) begin
            prim_rd_reg <= prim_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sec_we) begin
            sec_mem[wr_addr] <= sec_wdata;
        end
        if (cmd.ev_rd || cmd.dp_rd) begin
            sec_rd_reg <= sec_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_reg           <= TAU_RESET;
            evap_rate_reg     <= EVAP_RESET;
            evap_rate_sec_reg <= EVAP_RESET;
            floor_reg         <= '0;
            elite_factor_reg  <= ELITE_RESET;
            sec_en_reg        <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TAU:      tau_reg           <= cfg_data;
                REG_EVAP:     evap_rate_reg     <= cfg_data[15:0];
                REG_EVAP_SEC: evap_rate_sec_reg <= cfg_data[15:0];
                REG_FLOOR:    floor_reg         <= cfg_data;
                REG_ELITE:    elite_factor_reg  <= cfg_data[15:0];
                REG_SEC_EN:   sec_en_reg        <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cmd.addr_clr) begin
            addr_reg <= '0;
        end else if (cmd.fill || cmd.ev_wr) begin
            addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.fill && addr_reg == '0) begin
            sweep_val_reg <= fill_val;
        end else if (cmd.ev_wr && addr_reg == '0) begin
            sweep_val_reg <= prim_ev;
        end
        if (cmd.mul1) begin
            ll_reg <= 48'(item_reg.tour_length) * 48'(item_reg.tour_length);
            et_reg <= 48'(elite_factor_reg) * 48'(tau_reg);
        end
        if (cmd.mul2) begin
            llr_reg <= 64'(ll_reg) * 64'(evap_rate_reg);
        end
        if (cmd.mul3) begin
            den_reg <= 72'(llr_reg) * 72'(item_reg.passes);
            quo_reg <= item_reg.elite ? {et_reg, 8'b0} : {8'b0, tau_reg, 16'b0};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? 72'(rem_sh - {1'b0, den_reg}) : rem_sh[71:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.mul3) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        res_next = '0;
        case (cmd.res_kind)
            RES_ZERO_ARC: res_next.result_arc = item_reg.arc_index;
            RES_ENTRY: begin
                res_next.result_arc = item_reg.arc_index;
                res_next.pheromone  = entry;
            end
            RES_NEW: begin
                res_next.result_arc = item_reg.arc_index;
                res_next.pheromone  = new_val;
            end
            RES_SWEEP: begin
                res_next.pheromone = sweep_val_reg;
                res_next.done_res  = 1'b1;
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_reg <= res_next;
        end
        if (cmd.load_out) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.in_cmd    = item_reg.command;
    assign status.arc_ok    = 32'(item_reg.arc_index) < NUM_ARCS_W;
    assign status.dep_ok    = (item_reg.passes != '0)
                              && ((item_reg.command == CMD_DEP_PRI)
                              || ((item_reg.command == CMD_DEP_SEC) && sec_en_reg));
    assign status.last_addr = addr_reg == LAST_ADDR;
    assign status.div_last  = div_cnt_reg == 6'(DIV_STEPS - 1);
    assign status.out_free  = !m_valid_reg || m_ready;

    a_done_arc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> m_data_reg.result_arc == '0)
        else $error("Completed pass reported with a non-zero arc.");

    a_sweep_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fill || cmd.ev_wr) && status.last_addr |=> addr_reg == '0)
        else $error("Sweep address did not wrap after the last entry.");

endmodule

FILE: hw/rtl/ept_ctrl.sv
// Controller state machine sequencing table sweeps, deposits and result hand-off.
module ept_ctrl
    import ept_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_DECODE = 12'b0000_0000_0100,
        S_FILL   = 12'b0000_0000_1000,
        S_EV_RD  = 12'b0000_0001_0000,
        S_EV_WR  = 12'b0000_0010_0000,
        S_MUL2   = 12'b0000_0100_0000,
        S_MUL3   = 12'b0000_1000_0000,
        S_DIV    = 12'b0001_0000_0000,
        S_DP_WR  = 12'b0010_0000_0000,
        S_RD     = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.fill       = 1'b1;
                cmd.fill_reset = 1'b1;
                if (status.last_addr) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.addr_clr = 1'b1;
                case (status.in_cmd) inside
                    CMD_INIT: state_next = S_FILL;
                    CMD_EVAP: state_next = S_EV_RD;
                    CMD_DEP_PRI, CMD_DEP_SEC, CMD_RD_PRI, CMD_RD_SEC: begin
                        if (!status.arc_ok) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_kind = RES_ZERO_ARC;
                            state_next   = S_OUT;
                        end else if (status.dep_ok) begin
                            cmd.dp_rd  = 1'b1;
                            cmd.mul1   = 1'b1;
                            state_next = S_MUL2;
                        end else begin
                            cmd.dp_rd  = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = RES_NONE;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_FILL: begin
                cmd.fill = 1'b1;
                if (status.last_addr) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_SWEEP;
                    state_next   = S_OUT;
                end
            end
            S_EV_RD: begin
                cmd.ev_rd  = 1'b1;
                state_next = S_EV_WR;
            end
            S_EV_WR: begin
                cmd.ev_wr = 1'b1;
                if (status.last_addr) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_EV_RD;
                end
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_DP_WR;
                end
            end
            S_DP_WR: begin
                cmd.dp_wr    = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_kind = RES_NEW;
                state_next   = S_OUT;
            end
            S_RD: begin
                cmd.set_res  = 1'b1;
                cmd.res_kind = RES_ENTRY;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_EV_WR && status.last_addr) begin
            cmd.set_res  = 1'b1;
            cmd.res_kind = RES_SWEEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DECODE)
        else $error("Accepted request was not decoded in the next cycle.");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("Result loaded while the output register was still full.");

    a_write_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dp_wr |-> status.dep_ok && status.arc_ok)
        else $error("Deposit written for a request that must not change the table.");

endmodule
